>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

>>> rtl/tepq_pkg.sv
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared types, sizes and key compare for the timed event queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] due;
    logic [15:0] rank;
    logic [15:0] tag;
  } slot_t;

  // running best of a sweep along the cell row
  typedef struct packed {
    logic             found;
    logic [31:0]      rel;
    slot_t            slot;
    logic [IDX_W-1:0] idx;
  } carry_t;

  typedef struct packed {
    logic load;
    logic kill;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

  // due times compared as signed offsets from the current time, then rank
  function automatic logic key_lt(logic [31:0] a_rel, logic [15:0] a_rank,
                                  logic [31:0] b_rel, logic [15:0] b_rank);
    return ($signed(a_rel) < $signed(b_rel)) || ((a_rel == b_rel) && (a_rank < b_rank));
  endfunction

  function automatic logic rel_lt(logic [31:0] a_rel, logic [31:0] b_rel);
    return $signed(a_rel) < $signed(b_rel);
  endfunction

endpackage

>>> rtl/tepq_cell.sv
// ----------------------------------------------------------------------------
// tepq_cell
// One event slot of the queue row plus its stage of the minimum sweep.
// ----------------------------------------------------------------------------
module tepq_cell import tepq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  logic [31:0]      now,
  input  cell_ctl_t        ctl,
  input  slot_t            wr_slot,
  input  slot_t            key,
  input  logic             tok_in,
  input  carry_t           carry_in,
  output logic             tok_out,
  output carry_t           carry_out,
  output cell_stat_t       stat
);

  logic        valid;
  slot_t       slot;
  logic [31:0] own_rel;
  logic        take;
  carry_t      own_carry;

  assign own_rel = slot.due - now;
  // strict compare: on equal keys the earlier cell keeps the lead
  assign take = valid && (!carry_in.found ||
                key_lt(own_rel, slot.rank, carry_in.rel, carry_in.slot.rank));

  always_comb begin
    own_carry.found = 1'b1;
    own_carry.rel   = own_rel;
    own_carry.slot  = slot;
    own_carry.idx   = cell_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.kill) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot <= wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      carry_out <= take ? own_carry : carry_in;
    end
  end

  assign stat.valid = valid;
  assign stat.match = valid && (slot == key);

endmodule

>>> rtl/timed_event_priority_queue.sv
// ----------------------------------------------------------------------------
// timed_event_priority_queue
// Insert: result sent from the execute state; the next word is taken after it.
// Cancel: as insert; all cells match at once, only the lowest match is removed.
// Tick with F fired events: (F + 1) sweeps, made by the one search token
//   walking the cell row, then a result per fired event and a last one.
// Reset (rst, synchronous): store empty, time and earliest-due marker zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_event_priority_queue import tepq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // event_time[31:0], unit_id[39:32], priority_class[47:40], event_tag[63:48],
  // cycle_count[95:64]
  input  logic [95:0]  s_tdata,
  // func[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // fired_tag[15:0], fired_time[47:16], now_time[79:48], next_time[111:80],
  // next_rank[127:112]
  output logic [127:0] m_tdata,
  // kind[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  localparam logic [2:0] KIND_FIRED     = 3'd0;
  localparam logic [2:0] KIND_INS_OK    = 3'd1;
  localparam logic [2:0] KIND_INS_FULL  = 3'd2;
  localparam logic [2:0] KIND_CAN_FOUND = 3'd3;
  localparam logic [2:0] KIND_CAN_MISS  = 3'd4;
  localparam logic [2:0] KIND_TICK_DONE = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_LAUNCH, ST_WAIT, ST_EVAL, ST_DONE
  } state_t;

  state_t           state;
  logic [1:0]       req_func;
  slot_t            req_slot;
  logic [31:0]      tick_end;
  logic [31:0]      cur_time;
  logic [31:0]      mark_time;
  logic [15:0]      mark_rank;
  logic [CNT_W-1:0] entry_count;
  logic             fire_pend;
  slot_t            fire_slot;

  logic [QUEUE_DEPTH-1:0] tok;
  logic [QUEUE_DEPTH-1:0] tok_in;
  carry_t                 carry    [QUEUE_DEPTH];
  carry_t                 carry_in [QUEUE_DEPTH];
  cell_stat_t             stat     [QUEUE_DEPTH];
  cell_ctl_t              ctl      [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_match;

  logic             launch;
  logic             can_emit;
  logic             full;
  logic             any_match;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] match_idx;
  carry_t           res;
  logic [31:0]      end_rel;
  logic             nx_in;
  logic             ins_less;
  logic             ins_do;
  logic             can_do;
  logic             pop;

  logic             emit;
  logic [2:0]       emit_kind;
  logic [15:0]      emit_tag;
  logic [31:0]      emit_ftime;
  logic             emit_last;
  logic [31:0]      cur_time_next;
  logic [31:0]      mark_time_next;
  logic [15:0]      mark_rank_next;
  logic [CNT_W-1:0] entry_count_next;

  logic [127:0]     out_data;
  logic [2:0]       out_kind;
  logic             out_last;

  // ---------------------------------------------------------------- cell row
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g]   = launch;
      assign carry_in[g] = '0;
    end else begin : g_link
      assign tok_in[g]   = tok[g-1];
      assign carry_in[g] = carry[g-1];
    end

    assign ctl[g].load = ins_do && (free_idx == IDX_W'(g));
    assign ctl[g].kill = (can_do && (match_idx == IDX_W'(g))) ||
                         (pop && (res.idx == IDX_W'(g)));
    assign cell_valid[g] = stat[g].valid;
    assign cell_match[g] = stat[g].match;

    tepq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (IDX_W'(g)),
      .now       (cur_time),
      .ctl       (ctl[g]),
      .wr_slot   (req_slot),
      .key       (req_slot),
      .tok_in    (tok_in[g]),
      .carry_in  (carry_in[g]),
      .tok_out   (tok[g]),
      .carry_out (carry[g]),
      .stat      (stat[g])
    );
  end

  // lowest free and lowest matching slot
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!cell_valid[i]) free_idx = IDX_W'(i);
      if (cell_match[i])  match_idx = IDX_W'(i);
    end
  end

  assign any_match = |cell_match;
  assign s_tready  = (state == ST_IDLE);
  assign launch    = (state == ST_LAUNCH);
  assign can_emit  = !m_tvalid || m_tready;
  assign full      = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign res       = carry[QUEUE_DEPTH-1];
  assign end_rel   = tick_end - cur_time;
  assign nx_in     = res.found && rel_lt(res.rel, end_rel);
  assign ins_less  = key_lt(req_slot.due - cur_time, req_slot.rank,
                            mark_time - cur_time, mark_rank);

  assign ins_do = (state == ST_EXEC) && (req_func == FUNC_INSERT) && can_emit && !full;
  assign can_do = (state == ST_EXEC) && (req_func == FUNC_CANCEL) && can_emit && any_match;
  assign pop    = (state == ST_EVAL) && !fire_pend && res.found && !rel_lt(end_rel, res.rel);

  always_comb begin
    emit           = 1'b0;
    emit_kind      = KIND_TICK_DONE;
    emit_tag       = '0;
    emit_ftime     = '0;
    emit_last      = 1'b1;
    cur_time_next  = cur_time;
    mark_time_next = mark_time;
    mark_rank_next = mark_rank;
    case (state)
      ST_EXEC: begin
        if (can_emit) begin
          emit = 1'b1;
          case (req_func)
            FUNC_INSERT: begin
              if (full) begin
                emit_kind = KIND_INS_FULL;
              end else begin
                emit_kind = KIND_INS_OK;
                if (ins_less) begin
                  mark_time_next = req_slot.due;
                  mark_rank_next = req_slot.rank;
                end
              end
            end
            FUNC_CANCEL: begin
              emit_kind = any_match ? KIND_CAN_FOUND : KIND_CAN_MISS;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (fire_pend) begin
          // res holds the earliest event seen from the fired event's time
          if (can_emit) begin
            emit           = 1'b1;
            emit_kind      = KIND_FIRED;
            emit_tag       = fire_slot.tag;
            emit_ftime     = fire_slot.due;
            emit_last      = 1'b0;
            mark_time_next = nx_in ? res.slot.due  : tick_end;
            mark_rank_next = nx_in ? res.slot.rank : 16'd0;
          end
        end else if (pop) begin
          cur_time_next = res.slot.due;
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          emit          = 1'b1;
          emit_kind     = KIND_TICK_DONE;
          cur_time_next = tick_end;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    entry_count_next = entry_count;
    if (ins_do) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (can_do || pop) begin
      entry_count_next = entry_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      cur_time    <= '0;
      mark_time   <= '0;
      mark_rank   <= '0;
      entry_count <= '0;
      fire_pend   <= 1'b0;
    end else begin
      cur_time    <= cur_time_next;
      mark_time   <= mark_time_next;
      mark_rank   <= mark_rank_next;
      entry_count <= entry_count_next;

      if (emit) begin
        m_tvalid <= 1'b1;
        out_kind <= emit_kind;
        out_last <= emit_last;
        out_data <= {mark_rank_next, mark_time_next, cur_time_next, emit_ftime, emit_tag};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req_func      <= s_tuser;
            req_slot.due  <= s_tdata[31:0];
            req_slot.rank <= {s_tdata[47:40], s_tdata[39:32]};
            req_slot.tag  <= s_tdata[63:48];
            tick_end      <= cur_time + s_tdata[95:64];
            fire_pend     <= 1'b0;
            case (s_tuser)
              FUNC_INSERT: state <= ST_EXEC;
              FUNC_CANCEL: state <= ST_EXEC;
              FUNC_TICK:   state <= ST_LAUNCH;
              default:     state <= ST_IDLE;
            endcase
          end
        end
        ST_EXEC: begin
          if (can_emit) state <= ST_IDLE;
        end
        ST_LAUNCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (tok[QUEUE_DEPTH-1]) state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (fire_pend) begin
            if (can_emit) fire_pend <= 1'b0;
          end else if (pop) begin
            fire_slot <= res.slot;
            fire_pend <= 1'b1;
            state     <= ST_LAUNCH;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_emit) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  `ASSERT_PROP(a_count_matches_valid, clk, rst, entry_count == CNT_W'($countones(cell_valid)), "entry count disagrees with valid cells")
  `ASSERT_PROP(a_count_bounded, clk, rst, entry_count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `ASSERT_PROP(a_single_token, clk, rst, $onehot0(tok), "more than one search token in the row")
  `ASSERT_NEVER(a_idle_no_token, clk, rst, (state == ST_IDLE) && (tok != '0), "search token alive while idle")
  `ASSERT_NEVER(a_pop_only_valid, clk, rst, pop && !cell_valid[res.idx], "popped slot is not valid")

endmodule
